[hdl/vna_pkg.sv]
// vna_pkg: shared types, constants and index helpers of the vertex normal accumulator
// depends on nothing; imported by vna_sat_add and vertex_normal_accumulator

package vna_pkg;

	localparam int NUM_VERTICES = 4096;
	localparam int ADDR_W       = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
	localparam int VERTEX_W     = 12;
	localparam int SUM_W        = 32;
	localparam int OP_W         = 2;

	localparam logic [OP_W-1:0] OP_ACCUMULATE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ       = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE      = 2'd2;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_VERTICES - 1);

	typedef struct packed {
		logic signed [SUM_W-1:0] z;
		logic signed [SUM_W-1:0] y;
		logic signed [SUM_W-1:0] x;
	} sum3_t;

	typedef struct packed {
		logic  mark;
		sum3_t sums;
	} entry_t;

	typedef struct packed {
		logic  sat;
		sum3_t sums;
	} sat_res_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic logic idx_ok(input logic [VERTEX_W-1:0] idx);
		logic [ADDR_W+VERTEX_W-1:0] w;
		w = {{ADDR_W{1'b0}}, idx};
		return w < (ADDR_W+VERTEX_W)'(NUM_VERTICES);
	endfunction

	function automatic logic [ADDR_W-1:0] to_addr(input logic [VERTEX_W-1:0] idx);
		logic [ADDR_W+VERTEX_W-1:0] w;
		w = {{ADDR_W{1'b0}}, idx};
		return w[ADDR_W-1:0];
	endfunction

endpackage

[hdl/vna_ram.sv]
// vna_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module vna_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/vna_sat_add.sv]
// vna_sat_add: shared three-lane saturating adder used for every corner update
// depends on vna_pkg

module vna_sat_add
	import vna_pkg::*;
(
	input  sum3_t    acc,
	input  sum3_t    addend,
	output sat_res_t res
);

	logic [SUM_W:0] sx, sy, sz;
	logic           ovx, ovy, ovz;

	// one extra bit catches overflow: top two bits differ
	assign sx = {acc.x[SUM_W-1], acc.x} + {addend.x[SUM_W-1], addend.x};
	assign sy = {acc.y[SUM_W-1], acc.y} + {addend.y[SUM_W-1], addend.y};
	assign sz = {acc.z[SUM_W-1], acc.z} + {addend.z[SUM_W-1], addend.z};

	assign ovx = sx[SUM_W] ^ sx[SUM_W-1];
	assign ovy = sy[SUM_W] ^ sy[SUM_W-1];
	assign ovz = sz[SUM_W] ^ sz[SUM_W-1];

	always_comb begin
		res.sums.x = ovx ? (sx[SUM_W] ? SUM_MIN : SUM_MAX) : sx[SUM_W-1:0];
		res.sums.y = ovy ? (sy[SUM_W] ? SUM_MIN : SUM_MAX) : sy[SUM_W-1:0];
		res.sums.z = ovz ? (sz[SUM_W] ? SUM_MIN : SUM_MAX) : sz[SUM_W-1:0];
		res.sat    = ovx | ovy | ovz;
	end

endmodule

[hdl/vertex_normal_accumulator.sv]
// vertex_normal_accumulator: top level with the sequencer, vertex memory and result register
// depends on vna_pkg, vna_ram and vna_sat_add

// After reset the block sweeps the vertex memory to zero, one entry per cycle, over all
// NUM_VERTICES entries (4096), and takes no item until that is done. An accumulate item
// then visits its corners in turn and skips each out-of-range one: each in-range corner
// is a memory read followed by a saturating add and write back through the one shared
// adder on the single write port of the memory. A write item or an unused code is handled
// as it is taken in the idle state; a read item passes a memory read and a response step,
// which waits for out_ready while an earlier result is held. Indices at or above
// NUM_VERTICES are skipped on accumulate, ignored on write and read back as all zero.

module vertex_normal_accumulator
	import vna_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [OP_W-1:0]            operation,
	input  logic [VERTEX_W-1:0]        vertex_a,
	input  logic [VERTEX_W-1:0]        vertex_b,
	input  logic [VERTEX_W-1:0]        vertex_c,
	input  logic signed [SUM_W-1:0]    value_x,
	input  logic signed [SUM_W-1:0]    value_y,
	input  logic signed [SUM_W-1:0]    value_z,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SUM_W-1:0]    sum_x,
	output logic signed [SUM_W-1:0]    sum_y,
	output logic signed [SUM_W-1:0]    sum_z,
	output logic                       saturated
);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_RESP = 3'd4;

	logic [2:0]          state_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [1:0]          corner_q;
	logic [OP_W-1:0]     op_q;
	logic [VERTEX_W-1:0] va_q, vb_q, vc_q;
	sum3_t               val_q;
	logic                inrange_q;
	logic                out_valid_q;
	entry_t              out_q;

	logic                in_acc;
	logic [VERTEX_W-1:0] cur_idx;
	logic                cur_ok;
	logic                last_corner;
	logic                resp_load;

	logic                ram_we, ram_re;
	logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
	entry_t              ram_wdata, ram_rdata;
	sum3_t               in_val;
	sat_res_t            add_res;

	assign in_ready    = (state_q == ST_IDLE);
	assign in_acc      = in_valid & in_ready;
	assign in_val      = '{z: value_z, y: value_y, x: value_x};

	always_comb begin
		case (corner_q)
			2'd0:    cur_idx = va_q;
			2'd1:    cur_idx = vb_q;
			default: cur_idx = vc_q;
		endcase
	end

	assign cur_ok      = idx_ok(cur_idx);
	assign last_corner = (corner_q == 2'd2) || (op_q != OP_ACCUMULATE);
	assign resp_load   = (state_q == ST_RESP) && (!out_valid_q || out_ready);

	vna_sat_add u_add (
		.acc    (ram_rdata.sums),
		.addend (val_q),
		.res    (add_res)
	);

	// single write port: clearing sweep, direct write item, or corner write back
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = to_addr(cur_idx);
		ram_wdata = '0;
		case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ST_IDLE: begin
				ram_we         = in_acc && (operation == OP_WRITE) && idx_ok(vertex_a);
				ram_waddr      = to_addr(vertex_a);
				ram_wdata.mark = 1'b0;
				ram_wdata.sums = in_val;
			end
			ST_UPD: begin
				ram_we         = 1'b1;
				ram_wdata.mark = ram_rdata.mark | add_res.sat;
				ram_wdata.sums = add_res.sums;
			end
			default: ram_we = 1'b0;
		endcase
	end

	assign ram_re    = (state_q == ST_RD) && cur_ok;
	assign ram_raddr = to_addr(cur_idx);

	vna_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_VERTICES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			corner_q  <= '0;
			op_q      <= OP_ACCUMULATE;
			inrange_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						op_q     <= operation;
						corner_q <= '0;
						if (operation inside {OP_ACCUMULATE, OP_READ}) begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					inrange_q <= cur_ok;
					if (op_q == OP_READ) begin
						state_q <= ST_RESP;
					end else if (cur_ok) begin
						state_q <= ST_UPD;
					end else if (last_corner) begin
						state_q <= ST_IDLE;
					end else begin
						corner_q <= corner_q + 1'b1;
					end
				end
				ST_UPD: begin
					if (last_corner) begin
						state_q <= ST_IDLE;
					end else begin
						corner_q <= corner_q + 1'b1;
						state_q  <= ST_RD;
					end
				end
				ST_RESP: begin
					if (resp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload, held for the whole sequence
	always_ff @(posedge clk) begin
		if (in_acc) begin
			va_q  <= vertex_a;
			vb_q  <= vertex_b;
			vc_q  <= vertex_c;
			val_q <= in_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_load) begin
			out_q <= inrange_q ? ram_rdata : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign sum_x     = out_q.sums.x;
	assign sum_y     = out_q.sums.y;
	assign sum_z     = out_q.sums.z;
	assign saturated = out_q.mark;

	// no item is taken while the memory is still being cleared
	a_clr_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !in_ready)
		else $error("input ready during clearing sweep");

	// a result only appears after the response step of a read
	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_RESP) && ($past(op_q) == OP_READ))
		else $error("result produced without a read");

	// the read step never collides with a write on the memory
	a_no_write_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) || (state_q == ST_RESP) |-> !ram_we)
		else $error("memory write during read step");

	// a corner write back always follows a read of that same corner
	a_upd_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> ($past(state_q) == ST_RD) && $past(ram_re))
		else $error("write back without a preceding read");

endmodule
